>>> src/tns_pkg.sv
// Shared types and character constants for the text normaliser.
package tns_pkg;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'd32;

  typedef struct packed {
    logic joining;
    logic space_owed;
    logic after_space_or_start;
    logic after_period;
  } norm_state_t;

  localparam norm_state_t STATE_RESET = '{
    joining: 1'b0,
    space_owed: 1'b0,
    after_space_or_start: 1'b1,
    after_period: 1'b0
  };

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       last;
  } result_t;

  // Per-item outcome of the classifier
  typedef struct packed {
    logic [1:0]  count;
    result_t     first;
    result_t     second;
    norm_state_t state_next;
  } step_t;

endpackage

>>> src/tns_classify.sv
// Combinational byte classifier and state update for one input transfer.
module tns_classify import tns_pkg::*; (
  input  logic [7:0]  in_char,
  input  logic        end_of_text,
  input  norm_state_t state,
  output step_t       step
);

  logic [7:0]  c;
  logic        is_letter;
  logic [1:0]  n;
  result_t     r0;
  result_t     r1;
  norm_state_t s;

  always_comb begin
    if (in_char inside {[CH_UP_A:CH_UP_Z]}) begin
      c = in_char + CASE_GAP;
    end else if (in_char == CH_NL) begin
      c = CH_SPACE;
    end else if (in_char == CH_QUEST || in_char == CH_BANG) begin
      c = CH_PERIOD;
    end else begin
      c = in_char;
    end
    is_letter = c inside {[CH_LO_A:CH_LO_Z]};
  end

  always_comb begin
    s  = state;
    n  = 2'd0;
    r0 = '{out_char: 8'h00, has_char: 1'b0, last: 1'b0};
    r1 = '{out_char: 8'h00, has_char: 1'b0, last: 1'b0};

    if (c == CH_DASH) begin
      s.joining = 1'b1;
    end else if (state.joining && c == CH_SPACE) begin
      // swallowed by the join
    end else if (c == CH_PERIOD && !state.after_period) begin
      s.space_owed = 1'b0;
      r0 = '{out_char: CH_PERIOD, has_char: 1'b1, last: 1'b0};
      n = 2'd1;
      s.after_period = 1'b1;
      s.after_space_or_start = 1'b0;
      s.joining = 1'b0;
    end else if (c == CH_SPACE && !state.after_space_or_start && !state.after_period) begin
      s.space_owed = 1'b1;
      s.after_space_or_start = 1'b1;
      s.after_period = 1'b0;
    end else if (is_letter) begin
      if (state.space_owed) begin
        r0 = '{out_char: CH_SPACE, has_char: 1'b1, last: 1'b0};
        r1 = '{out_char: c, has_char: 1'b1, last: 1'b0};
        n = 2'd2;
      end else begin
        r0 = '{out_char: c, has_char: 1'b1, last: 1'b0};
        n = 2'd1;
      end
      s.space_owed = 1'b0;
      s.after_space_or_start = 1'b0;
      s.after_period = 1'b0;
      s.joining = 1'b0;
    end

    if (end_of_text) begin
      case (n)
        2'd0: begin
          r0 = '{out_char: 8'h00, has_char: 1'b0, last: 1'b1};
          n = 2'd1;
        end
        2'd1: r0.last = 1'b1;
        2'd2: r1.last = 1'b1;
        default: r0.last = 1'b1;
      endcase
      s = STATE_RESET;
    end

    step.count      = n;
    step.first      = r0;
    step.second     = r1;
    step.state_next = s;
  end

endmodule

>>> src/tns_out_buffer.sv
// Two-entry result register between the classifier and the output channel.
module tns_out_buffer import tns_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [1:0] push_count,
  input  result_t    push_first,
  input  result_t    push_second,
  output logic       can_push,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    head
);

  result_t    slot0;
  result_t    slot1;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign head      = slot0;
  // Room for a worst-case pair once this cycle's transfer has left
  assign can_push  = (count == 2'd0) || (count == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push) begin
      count <= push_count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= push_first;
      slot1 <= push_second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result buffer count out of range");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push && count != 2'd0 |-> count == 2'd1 && pop)
    else $error("push into a buffer that still holds results");
`endif

endmodule

>>> src/text_normalizer_stream.sv
// Top level of the streaming text normaliser.
// One text byte is taken per cycle and cleaned to lower-case letters, single
// spaces and periods; a held space is released only before the next letter,
// so a letter that releases one gives two results and the input stalls
// while the pair drains. All rules are evaluated combinationally from the
// four-bit state register; results wait in a two-entry output register, and a
// byte is taken only while that register has room for a pair once this cycle's
// output transfer has left, so a result that is not taken holds the input. With
// out_ready high the rate is one item per cycle apart from those pair stalls.
// The final byte of a text always yields a result with last set (a bare
// marker with has_char low if it emits nothing) and returns the state to reset.
module text_normalizer_stream import tns_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       has_char,
  output logic       last
);

  norm_state_t state;
  step_t       step;
  result_t     head;
  logic        accept;
  logic        can_push;

  assign in_ready = can_push;
  assign accept   = in_valid && in_ready;

  tns_classify u_classify (
    .in_char     (in_char),
    .end_of_text (end_of_text),
    .state       (state),
    .step        (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= step.state_next;
    end
  end

  tns_out_buffer u_out_buffer (
    .clk         (clk),
    .rst         (rst),
    .push        (accept && step.count != 2'd0),
    .push_count  (step.count),
    .push_first  (step.first),
    .push_second (step.second),
    .can_push    (can_push),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .head        (head)
  );

  assign out_char = head.out_char;
  assign has_char = head.has_char;
  assign last     = head.last;

`ifndef NO_ASSERTIONS
  a_bare_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> last)
    else $error("bare end marker without last");
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_text |=> state == STATE_RESET)
    else $error("state not cleared after end of text");
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_char |->
      (out_char >= CH_LO_A && out_char <= CH_LO_Z) ||
      out_char == CH_SPACE || out_char == CH_PERIOD)
    else $error("emitted byte outside the cleaned set");
  a_owed_after_space: assert property (@(posedge clk) disable iff (rst)
    state.space_owed |-> state.after_space_or_start && !state.after_period)
    else $error("held space in inconsistent state");
`endif

endmodule

>>> tb/tb_text_normalizer_stream.sv
// Self-checking testbench for the streaming text normaliser.
module tb_text_normalizer_stream;
  import tns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       hold;  // sender waits here until every expected result is in
  } text_byte_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       has_char;
  logic       last;

  text_byte_t  byte_q [$];
  result_t     clean_q [$];
  norm_state_t text_st = STATE_RESET;
  int          failures = 0;
  int          cyc = 0;
  logic        calm;

  text_normalizer_stream dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char(in_char), .end_of_text(end_of_text),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_char(out_char), .has_char(has_char), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // no idling on either side through this window
  assign calm = (cyc >= 300) && (cyc < 700);

  always @(posedge clk) cyc <= cyc + 1;

  // Cleans one byte against the running text state and queues what it yields
  function automatic void predict_clean(input logic [7:0] raw, input logic eot);
    logic [7:0] c;
    result_t    res [2];
    int         n;
    c = raw;
    n = 0;
    if (c >= CH_UP_A && c <= CH_UP_Z) c = c + CASE_GAP;
    else if (c == CH_NL) c = CH_SPACE;
    else if (c == CH_QUEST || c == CH_BANG) c = CH_PERIOD;

    if (c == CH_DASH) begin
      text_st.joining = 1'b1;
    end else if (text_st.joining && c == CH_SPACE) begin
      // swallowed by the join
    end else if (c == CH_PERIOD && !text_st.after_period) begin
      text_st.space_owed = 1'b0;
      res[n] = '{out_char: CH_PERIOD, has_char: 1'b1, last: 1'b0};
      n++;
      text_st.after_period = 1'b1;
      text_st.after_space_or_start = 1'b0;
      text_st.joining = 1'b0;
    end else if (c == CH_SPACE && !text_st.after_space_or_start && !text_st.after_period) begin
      text_st.space_owed = 1'b1;
      text_st.after_space_or_start = 1'b1;
      text_st.after_period = 1'b0;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      if (text_st.space_owed) begin
        res[n] = '{out_char: CH_SPACE, has_char: 1'b1, last: 1'b0};
        n++;
      end
      text_st.space_owed = 1'b0;
      res[n] = '{out_char: c, has_char: 1'b1, last: 1'b0};
      n++;
      text_st.after_space_or_start = 1'b0;
      text_st.after_period = 1'b0;
      text_st.joining = 1'b0;
    end

    if (eot) begin
      if (n == 0) begin
        res[0] = '{out_char: 8'h00, has_char: 1'b0, last: 1'b0};
        n = 1;
      end
      res[n-1].last = 1'b1;
      text_st = STATE_RESET;
    end
    for (int i = 0; i < n; i++) clean_q.push_back(res[i]);
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic eot);
    byte_q.push_back('{ch: b, eot: eot, hold: 1'b0});
  endtask

  task automatic add_hold();
    byte_q.push_back('{ch: 8'h00, eot: 1'b0, hold: 1'b1});
  endtask

  task automatic add_text(input string s, input logic terminate);
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i], terminate && (i == s.len() - 1));
  endtask

  // Mostly words with mixed case and separators, some raw noise bytes
  task automatic add_random_text(inout int total);
    int         len;
    int         pick;
    logic [7:0] b;
    len = $urandom_range(1, 30);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 10)
        b = ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'($urandom_range(0, 25));
      else if (pick < 13) b = CH_SPACE;
      else if (pick == 13) b = CH_NL;
      else if (pick == 14) b = CH_DASH;
      else if (pick == 15) b = CH_PERIOD;
      else if (pick == 16) b = $urandom_range(0, 1) ? CH_QUEST : CH_BANG;
      else b = 8'($urandom_range(0, 255));
      add_byte(b, k == len - 1);
      total++;
    end
  endtask

  // Sender
  always @(posedge clk) begin : drv
    text_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (byte_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (byte_q[0].hold) begin
        in_valid <= 1'b0;
        if (!in_valid && clean_q.size() == 0) nxt = byte_q.pop_front();
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        in_valid <= 1'b0;
      end else begin
        nxt = byte_q.pop_front();
        in_valid <= 1'b1;
        in_char <= nxt.ch;
        end_of_text <= nxt.eot;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(0, 99) >= 30);
  end

  // Prediction on input transfers, checking on output transfers
  always @(posedge clk) begin : mon
    result_t want;
    if (!rst) begin
      if (in_valid && in_ready) predict_clean(in_char, end_of_text);
      if (out_valid && out_ready) begin
        if (clean_q.size() == 0) begin
          $error("unexpected result: out_char %h has_char %b last %b",
                 out_char, has_char, last);
          failures++;
        end else begin
          want = clean_q.pop_front();
          if (out_char !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, out_char);
            failures++;
          end
          if (has_char !== want.has_char) begin
            $error("has_char: expected %b, got %b", want.has_char, has_char);
            failures++;
          end
          if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    int total;
    total = 0;
    // leading and repeated periods, case folding, dash join, newline, held space at end
    add_text(".!Ab  -  cZ \n?x ", 1'b1);
    // bytes that are dropped, then a space before a period
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_text("q .", 1'b1);
    // a text whose only byte emits nothing
    add_byte("#", 1'b1);
    add_hold();
    while (total < 900) begin
      add_random_text(total);
      if (total >= 450 && total < 480) add_hold();
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || in_valid || clean_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0)
      $display("text_normalizer_stream: match");
    else
      $display("text_normalizer_stream: mismatch");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("text_normalizer_stream: mismatch");
    $finish;
  end

endmodule

>>> text_normalizer_stream.f
src/tns_pkg.sv
src/tns_classify.sv
src/tns_out_buffer.sv
src/text_normalizer_stream.sv
tb/tb_text_normalizer_stream.sv
